### hdl/a32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a32_pkg: shared constants for the Adler-32 multi-byte checksum block
// Holds the modulus, the folding constant and the reset defaults.
// ----------------------------------------------------------------------------
package a32_pkg;

	// Adler-32 modulus and 2^16 mod 65521, used to fold the upper bits.
	localparam logic [16:0] ADLER_BASE = 17'd65521;
	localparam logic [16:0] FOLD_K     = 17'd15;

	// Reset value of the seed register: s2 = 0, s1 = 1.
	localparam logic [31:0] SEED_RESET = 32'h0000_0001;

	// Default number of byte lanes per item.
	localparam int DEFAULT_LANES = 8;

	// Number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Width of one queue entry: last flag, count, byte sum and weighted sum.
	function automatic int a32_front_w(int l);
		return 1 + $clog2(l + 1) + $clog2(l * 255 + 1)
			+ $clog2(l * (l + 1) / 2 * 255 + 1);
	endfunction

endpackage

### hdl/adler32_multi_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adler32_multi_byte: Adler-32 checksum, up to LANES bytes per item
// Input items carry data_bytes, byte_count and last_item on a valid/ready
// channel; byte 0 in bits 7:0 comes first in the stream. Each item updates
// s1 and s2 modulo 65521. A last item returns s2 << 16 | s1 on the checksum
// channel and reloads the sums from the seed register.
//
// The seed is written through seed_we / seed_wdata while no message is in
// flight; it takes effect at the next reload. Reset sets the seed to 1 and
// the sums to s1 = 1, s2 = 0, and empties the queue and the result slot.
//
// Throughput is one item per cycle while the queue has room. The front forms
// the lane sums and puts the item in a two-entry queue; the back applies it
// to s1 and s2 in a single modular update that sets the one-item-per-cycle
// figure. An accepted item is registered in the queue, and the checksum of a
// last item is registered in the result slot. While the receiver stalls, the
// back keeps taking items that are not last; a last item waits in the queue
// until the result slot frees, and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module adler32_multi_byte #(
	parameter int LANES = a32_pkg::DEFAULT_LANES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  byte_count,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] checksum
);
	import a32_pkg::*;

	localparam int ENTRY_W = a32_front_w(LANES);

	logic [31:0]        seed_q;
	logic [ENTRY_W-1:0] entry;
	logic [ENTRY_W-1:0] head;
	logic               q_full;
	logic               q_valid;
	logic               push;
	logic               pop;

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	a32_front #(
		.LANES (LANES)
	) u_front (
		.data_bytes (data_bytes),
		.byte_count (byte_count),
		.last_item  (last_item),
		.entry      (entry)
	);

	a32_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid)
	);

	a32_back #(
		.LANES (LANES),
		.WIDTH (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.head       (head),
		.head_valid (q_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.checksum   (checksum)
	);

endmodule

### hdl/a32_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a32_front: item classification and lane sums
// Saturates the byte count, masks the unused lanes and forms the plain byte
// sum and the position-weighted byte sum of one item.
// ----------------------------------------------------------------------------
module a32_front #(
	parameter int LANES = a32_pkg::DEFAULT_LANES
) (
	input  logic [63:0]                             data_bytes,
	input  logic [3:0]                              byte_count,
	input  logic                                    last_item,
	output logic [a32_pkg::a32_front_w(LANES)-1:0]  entry
);
	import a32_pkg::*;

	localparam int CNT_W = $clog2(LANES + 1);
	localparam int B_W   = $clog2(LANES * 255 + 1);
	localparam int W_W   = $clog2(LANES * (LANES + 1) / 2 * 255 + 1);
	localparam int PW    = CNT_W + B_W;
	localparam int DW    = LANES * 8;

	logic [DW-1:0]    lane_data;
	logic [4:0]       cnt_ext;
	logic [4:0]       cnt_sat;
	logic [CNT_W-1:0] n;
	logic [B_W-1:0]   bsum;
	logic [PW-1:0]    psum;
	logic [PW-1:0]    nb;
	logic [PW-1:0]    wfull;

	// Lanes past the 64-bit data word read as zero bytes.
	generate
		if (DW >= 64) begin : g_wide
			assign lane_data = DW'(data_bytes);
		end else begin : g_narrow
			assign lane_data = data_bytes[DW-1:0];
		end
	endgenerate

	// A count above the lane number saturates to the lane number.
	always_comb begin
		cnt_ext = {1'b0, byte_count};
		cnt_sat = (cnt_ext > 5'(LANES)) ? 5'(LANES) : cnt_ext;
		n = cnt_sat[CNT_W-1:0];
	end

	// Byte sum and index-weighted sum over the valid lanes.
	always_comb begin
		logic [7:0] mb;
		bsum = '0;
		psum = '0;
		for (int i = 0; i < LANES; i++) begin
			mb = (i < int'(n)) ? lane_data[8*i +: 8] : 8'd0;
			bsum = bsum + B_W'(mb);
			psum = psum + PW'(mb) * PW'(CNT_W'(i));
		end
	end

	// The weight of lane i is n - i, so the weighted sum is n*B minus the
	// index-weighted sum.
	always_comb begin
		nb    = PW'(n) * PW'(bsum);
		wfull = nb - psum;
	end

	assign entry = {last_item, n, bsum, wfull[W_W-1:0]};

endmodule

### hdl/a32_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a32_queue: short queue between the front and the back
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module a32_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = a32_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty
);
	import a32_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/a32_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a32_back: running sums and result register
// Applies one item per cycle, while no last item waits on a full result slot,
// to s1 and s2 modulo 65521, holding a last item's checksum until it is taken.
// ----------------------------------------------------------------------------
module a32_back #(
	parameter int LANES = a32_pkg::DEFAULT_LANES,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      seed,
	input  logic [WIDTH-1:0] head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      checksum
);
	import a32_pkg::*;

	localparam int CNT_W = $clog2(LANES + 1);
	localparam int B_W   = $clog2(LANES * 255 + 1);
	localparam int W_W   = $clog2(LANES * (LANES + 1) / 2 * 255 + 1);
	localparam int P_W   = CNT_W + 16;
	localparam int T_W   = $clog2(65535 * (LANES + 1) + LANES * (LANES + 1) / 2 * 255 + 1);
	localparam int H_W   = T_W - 16;

	logic             last;
	logic [CNT_W-1:0] n;
	logic [B_W-1:0]   bsum;
	logic [W_W-1:0]   wsum;

	logic [15:0]      s1_q;
	logic [15:0]      s2_q;
	logic             out_valid_q;
	logic [31:0]      checksum_q;

	logic [16:0]      a_sum;
	logic [15:0]      s1_new;
	logic [P_W-1:0]   prod;
	logic [T_W-1:0]   t_sum;
	logic [H_W-1:0]   t_hi;
	logic [16:0]      fold;
	logic [15:0]      s2_new;

	assign {last, n, bsum, wsum} = head;

	// A last item needs a free result slot; other items always go.
	assign pop = head_valid && (!last || !out_valid_q || out_ready);

	// s1: one add, then one conditional subtract of the modulus.
	always_comb begin
		a_sum  = {1'b0, s1_q} + 17'(bsum);
		s1_new = (a_sum >= ADLER_BASE) ? 16'(a_sum - ADLER_BASE) : a_sum[15:0];
	end

	// s2: add the weighted sum and count times old s1, fold the bits above
	// 16 with 2^16 = 15 mod 65521, then one conditional subtract.
	always_comb begin
		prod  = P_W'(n) * P_W'(s1_q);
		t_sum = T_W'(s2_q) + T_W'(wsum) + T_W'(prod);
		t_hi  = t_sum[T_W-1:16];
		fold  = 17'(t_sum[15:0]) + 17'(t_hi) * FOLD_K;
		s2_new = (fold >= ADLER_BASE) ? 16'(fold - ADLER_BASE) : fold[15:0];
	end

	// Running sums; a last item reloads them from the seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= SEED_RESET[15:0];
			s2_q <= SEED_RESET[31:16];
		end else if (pop) begin
			if (last) begin
				s1_q <= seed[15:0];
				s2_q <= seed[31:16];
			end else begin
				s1_q <= s1_new;
				s2_q <= s2_new;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			checksum_q <= {s2_new, s1_new};
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule

### tb/adler32_multi_byte_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adler32_multi_byte_test: self-checking bench for the multi-byte Adler-32
// Drives byte items with valid/ready and random gaps on both sides. A
// scoreboard class folds every accepted item into its own copy of s1 and s2.
// It queues the checksum that each last item must return and compares every
// returned checksum with the oldest one. The seed register is written
// between phases while the block is idle, with extreme and random values.
// ----------------------------------------------------------------------------
module adler32_multi_byte_test;

	localparam int LANES       = a32_pkg::DEFAULT_LANES;
	localparam int OUT_LATENCY = 2;
	localparam int DRAIN_WAIT  = 4 * OUT_LATENCY;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;

	// Scoreboard: running sums, seed copy and the checksums still owed.
	class checksum_board;
		logic [31:0] seed_copy;
		logic [15:0] sum_a;
		logic [15:0] sum_b;
		logic [31:0] owed_sums[$];
		int          error_count;
		int          items_seen;
		int          sums_checked;

		function void reload();
			sum_a = seed_copy[15:0];
			sum_b = seed_copy[31:16];
		endfunction

		function void reset_state();
			seed_copy = a32_pkg::SEED_RESET;
			reload();
			owed_sums.delete();
		endfunction

		// The new seed only takes effect at the next reload.
		function void set_seed(logic [31:0] value);
			seed_copy = value;
		endfunction

		function int pending();
			return owed_sums.size();
		endfunction

		// Fold one accepted item into the sums; a last item owes a checksum.
		function void note_input(logic [63:0] data, logic [3:0] count, logic last);
			int unsigned s1;
			int unsigned s2;
			int unsigned n;
			int unsigned lane_byte;
			s1 = sum_a;
			s2 = sum_b;
			n = count;
			items_seen++;
			if (n > LANES) begin
				n = LANES;
			end
			for (int unsigned i = 0; i < n; i++) begin
				lane_byte = 0;
				if (i < 8) begin
					lane_byte = data[8 * i +: 8];
				end
				s1 += lane_byte;
				s2 += s1;
			end
			s1 = s1 % a32_pkg::ADLER_BASE;
			s2 = s2 % a32_pkg::ADLER_BASE;
			sum_a = s1[15:0];
			sum_b = s2[15:0];
			if (last) begin
				owed_sums.push_back({sum_b, sum_a});
				reload();
			end
		endfunction

		// Compare a returned checksum with the oldest one owed.
		function void check_result(logic [31:0] actual);
			logic [31:0] wanted;
			if (owed_sums.size() == 0) begin
				$error("checksum: none expected, actual %08h", actual);
				error_count++;
				return;
			end
			wanted = owed_sums.pop_front();
			sums_checked++;
			if (actual !== wanted) begin
				$error("checksum: expected %08h, actual %08h", wanted, actual);
				error_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        seed_we;
	logic [31:0] seed_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] data_bytes;
	logic [3:0]  byte_count;
	logic        last_item;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] checksum;

	checksum_board board;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;
	int message_count;

	adler32_multi_byte #(
		.LANES(LANES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.last_item (last_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

	always #1 clk = ~clk;

	// Run limit, counted in rising edges.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: stall at random, decided at the falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every checksum taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(checksum);
		end
	end

	// Offer one item, entered and left at a falling edge.
	task automatic send_item(logic [63:0] data, logic [3:0] count, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_bytes <= data;
		byte_count <= count;
		last_item  <= last;
		do begin
			@(posedge clk);
		end while (!in_ready);
		board.note_input(data, count, last);
		if (last) begin
			message_count++;
		end
		@(negedge clk);
	endtask

	// Let every owed checksum come back, then let the pipeline settle.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (board.pending() > 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_seed(logic [31:0] value);
		seed_we    <= 1'b1;
		seed_wdata <= value;
		@(posedge clk);
		board.set_seed(value);
		@(negedge clk);
		seed_we <= 1'b0;
	endtask

	// Directed items: zero and saturated counts, all-ones and all-zero data.
	task automatic run_directed();
		send_item(64'h0, 4'd0, 1'b1);
		for (int c = 0; c < 16; c++) begin
			send_item({64{1'b1}}, 4'(c), (c == 7) || (c == 15));
		end
		send_item(64'h0, 4'd8, 1'b1);
		send_item(64'h0123_4567_89ab_cdef, 4'd8, 1'b0);
		send_item(64'hfedc_ba98_7654_3210, 4'd3, 1'b1);
		send_item(64'h8000_0000_0000_0001, 4'd1, 1'b1);
	endtask

	// Random messages: mostly full items, some odd counts and all-ones data.
	task automatic run_random(int total);
		int          left;
		int          len;
		int          pick;
		logic [63:0] data;
		logic [3:0]  count;
		left = total;
		while (left > 0) begin
			len = $urandom_range(12, 1);
			if (len > left) begin
				len = left;
			end
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(99);
				data = {$urandom, $urandom};
				if (pick < 10) begin
					data = {64{1'b1}};
				end
				count = 4'd8;
				if (pick >= 70 && pick < 85) begin
					count = 4'($urandom_range(8, 1));
				end else if (pick >= 85) begin
					count = 4'($urandom_range(15));
				end
				send_item(data, count, k == len - 1);
			end
			left -= len;
		end
	endtask

	// Main sequence: reset, directed part, then four random phases.
	initial begin
		logic [31:0] seeds[4];
		int          send_mix[4];
		int          recv_mix[4];
		board = new();
		board.reset_state();
		seeds    = '{32'hffff_ffff, 32'h0000_0000, $urandom, 32'hfff1_fff0};
		send_mix = '{0, 60, 0, 20};
		recv_mix = '{0, 0, 60, 20};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cycle_count    = 0;
		message_count  = 0;
		arst_n     <= 1'b0;
		seed_we    <= 1'b0;
		seed_wdata <= 32'h0;
		in_valid   <= 1'b0;
		data_bytes <= 64'h0;
		byte_count <= 4'd0;
		last_item  <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		for (int p = 0; p < 4; p++) begin
			drain_block();
			write_seed(seeds[p]);
			send_idle_pct  = send_mix[p];
			recv_stall_pct = recv_mix[p];
			run_random(PHASE_ITEMS);
		end
		drain_block();

		$display("Covered %0d items in %0d messages under five seeds and four idle mixes.",
			board.items_seen, message_count);
		$display("Compared %0d checksums in %0d cycles.", board.sums_checked, cycle_count);
		if (board.error_count == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
